// ===== rtl/htm_pkg.sv =====
// Shared types and constants for the Huffman tree merge table.
// No dependencies; htm_min_scan and the top level in rtl/ import this package.
package htm_pkg;

    localparam int TABLE_SLOTS = 512;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int IDX_W       = 9;
    localparam int WEIGHT_W    = 32;
    localparam int SYM_W       = 8;

    typedef enum logic [1:0] {
        FN_CLEAR = 2'd0,
        FN_LOAD  = 2'd1,
        FN_MERGE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_ROOM   = 2'd1,
        STS_FEW_NODES = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_A,
        S_MARK_A,
        S_SCAN_B,
        S_MARK_B,
        S_PARENT,
        S_DONE
    } state_t;

    // One table slot as held in the node RAM.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                used;
        logic                leaf;
        logic [SYM_W-1:0]    symbol;
        logic [IDX_W-1:0]    left;
        logic [IDX_W-1:0]    right;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Result of one minimum scan.
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] idx;
        node_t             entry;
    } scan_res_t;

    // Fields of one result item that the control path fills in.
    typedef struct packed {
        logic [IDX_W-1:0]    slot;
        logic [WEIGHT_W-1:0] node_weight;
        logic [IDX_W-1:0]    left_child;
        logic [IDX_W-1:0]    right_child;
        status_t             status;
    } result_t;

    function automatic logic [IDX_W-1:0] cnt_to_idx(input logic [CNT_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/htm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module htm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/htm_min_scan.sv =====
// Minimum scan over the filled slots of the node RAM, one slot per cycle.
// Depends on htm_pkg; drives the read port of the node RAM.
module htm_min_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [htm_pkg::CNT_W-1:0] limit,
    output logic                      rd_en,
    output logic [htm_pkg::SLOT_W-1:0] rd_addr,
    input  htm_pkg::node_t            rd_data,
    output htm_pkg::scan_res_t        res
);
    import htm_pkg::*;

    logic              run_reg,   run_next;
    logic [CNT_W-1:0]  addr_reg,  addr_next;
    logic              vld_reg,   vld_next;
    logic [SLOT_W-1:0] idx_reg,   idx_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] best_idx_reg, best_idx_next;
    node_t             best_reg,  best_next;
    logic              issue;
    logic              take;
    logic              done;

    assign issue = run_reg && (addr_reg < limit);
    assign done  = run_reg && !issue && !vld_reg;
    // Unused node, strictly lighter than the best so far: lowest index wins ties.
    assign take  = vld_reg && !rd_data.used &&
                   (!found_reg || (rd_data.weight < best_reg.weight));

    always_comb
    begin
        run_next      = run_reg;
        addr_next     = addr_reg;
        vld_next      = issue;
        idx_next      = addr_reg[SLOT_W-1:0];
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        if (take)
        begin
            found_next    = 1'b1;
            best_idx_next = idx_reg;
            best_next     = rd_data;
        end
        if (issue)
        begin
            addr_next = addr_reg + CNT_W'(1);
        end
        if (done)
        begin
            run_next = 1'b0;
        end
        if (start)
        begin
            run_next   = 1'b1;
            addr_next  = '0;
            vld_next   = 1'b0;
            found_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            addr_reg  <= '0;
            vld_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            run_reg   <= run_next;
            addr_reg  <= addr_next;
            vld_reg   <= vld_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
    end

    assign rd_en     = issue;
    assign rd_addr   = addr_reg[SLOT_W-1:0];
    assign res.done  = done;
    assign res.idx   = best_idx_reg;
    assign res.entry = best_reg;

endmodule

// ===== rtl/huffman_tree_merge_table.sv =====
// Top level of the Huffman tree merge table: control sequencer and result register.
// Depends on htm_pkg, htm_ram (node table) and htm_min_scan (minimum search).
//
//  channel  dir  tdata (low bit up)                           tuser
//  -------  ---  -------------------------------------------  -----------
//  s_*      in   symbol[7:0], weight[39:8]                    func[1:0]
//  m_*      out  slot, node_weight, left_child, right_child,  status[1:0]
//                has_room, root_ready, zero pad to 64 bits
//
// One item at a time. Clear, load, unused codes and rejected merges go from S_DECODE
// straight to S_DONE; the next item is accepted once the block is back in S_IDLE.
// A merge scans the table twice: the node RAM has one read port, so the two minimum
// scans run in turn, each reading one slot per cycle up to the fill count.
// Reset clears the state, m_tvalid and the fill and unused counts; the node RAM needs
// no clearing pass since only slots below the fill count are ever read.
// A finished result waits in the output register; the next item is accepted
// and worked on meanwhile, and only its completion waits for m_tready.
module huffman_tree_merge_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // symbol[7:0], weight[39:8]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // slot[8:0], node_weight[40:9], left_child[49:41],
                                   // right_child[58:50], has_room[59], root_ready[60]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import htm_pkg::*;

    state_t              state_reg, state_next;
    func_t               func_reg;
    logic [SYM_W-1:0]    sym_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [CNT_W-1:0]    fill_reg,   fill_next;
    logic [CNT_W-1:0]    unused_reg, unused_next;
    logic [SLOT_W-1:0]   a_idx_reg;
    logic [WEIGHT_W-1:0] wa_reg;
    logic [SLOT_W-1:0]   b_idx_reg;
    logic [WEIGHT_W-1:0] sum_reg;
    result_t             res_reg,    res_next;
    result_t             out_res_reg;
    logic                out_room_reg, out_root_reg;
    logic                m_tvalid_reg, m_tvalid_next;

    // RAM and scan control
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    node_t               ram_wdata;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [NODE_W-1:0]   ram_rdata;
    logic                scan_start;
    scan_res_t           scan_res;

    logic                accept;
    logic                full;
    logic                few;
    logic                out_free;
    logic [WEIGHT_W:0]   sum_wide;
    node_t               marked;

    assign accept   = s_tvalid && s_tready;
    assign full     = (fill_reg >= CNT_W'(TABLE_SLOTS));
    assign few      = (unused_reg < CNT_W'(2));
    assign out_free = !m_tvalid_reg || m_tready;
    assign sum_wide = {1'b0, wa_reg} + {1'b0, scan_res.entry.weight};

    always_comb
    begin
        marked      = scan_res.entry;
        marked.used = 1'b1;
    end

    htm_ram #(
        .WIDTH (NODE_W),
        .DEPTH (TABLE_SLOTS)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    htm_min_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .limit   (fill_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (node_t'(ram_rdata)),
        .res     (scan_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (func_reg == FN_MERGE && !few && !full)
                begin
                    state_next = S_SCAN_A;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_A:
            begin
                if (scan_res.done)
                begin
                    state_next = S_MARK_A;
                end
            end
            S_MARK_A:
            begin
                state_next = S_SCAN_B;
            end
            S_SCAN_B:
            begin
                if (scan_res.done)
                begin
                    state_next = S_MARK_B;
                end
            end
            S_MARK_B:
            begin
                state_next = S_PARENT;
            end
            S_PARENT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: RAM writes, scan starts, input ready
    always_comb
    begin
        s_tready   = 1'b0;
        scan_start = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = fill_reg[SLOT_W-1:0];
        ram_wdata  = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_DECODE:
            begin
                if (func_reg == FN_LOAD && !full)
                begin
                    ram_we           = 1'b1;
                    ram_wdata.weight = w_reg;
                    ram_wdata.leaf   = 1'b1;
                    ram_wdata.symbol = sym_reg;
                end
                scan_start = (func_reg == FN_MERGE) && !few && !full;
            end
            S_MARK_A:
            begin
                // mark the first minimum used, then rescan
                ram_we     = 1'b1;
                ram_waddr  = scan_res.idx;
                ram_wdata  = marked;
                scan_start = 1'b1;
            end
            S_MARK_B:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_res.idx;
                ram_wdata = marked;
            end
            S_PARENT:
            begin
                ram_we           = 1'b1;
                ram_wdata.weight = sum_reg;
                ram_wdata.left   = slot_to_idx(a_idx_reg);
                ram_wdata.right  = slot_to_idx(b_idx_reg);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Counts and the pending result
    always_comb
    begin
        fill_next   = fill_reg;
        unused_next = unused_reg;
        res_next    = res_reg;
        case (state_reg)
            S_DECODE:
            begin
                res_next = '{slot: '0, node_weight: '0, left_child: '0,
                             right_child: '0, status: STS_OK};
                case (func_reg)
                    FN_CLEAR:
                    begin
                        fill_next   = '0;
                        unused_next = '0;
                    end
                    FN_LOAD:
                    begin
                        if (full)
                        begin
                            res_next.status = STS_NO_ROOM;
                        end
                        else
                        begin
                            res_next.slot        = cnt_to_idx(fill_reg);
                            res_next.node_weight = w_reg;
                            fill_next            = fill_reg + CNT_W'(1);
                            unused_next          = unused_reg + CNT_W'(1);
                        end
                    end
                    FN_MERGE:
                    begin
                        if (few)
                        begin
                            res_next.status = STS_FEW_NODES;
                        end
                        else if (full)
                        begin
                            res_next.status = STS_NO_ROOM;
                        end
                    end
                    default:
                    begin
                        res_next.status = STS_OK;
                    end
                endcase
            end
            S_PARENT:
            begin
                res_next.slot        = cnt_to_idx(fill_reg);
                res_next.node_weight = sum_reg;
                res_next.left_child  = slot_to_idx(a_idx_reg);
                res_next.right_child = slot_to_idx(b_idx_reg);
                fill_next            = fill_reg + CNT_W'(1);
                unused_next          = unused_reg - CNT_W'(1);
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    assign m_tvalid_next = (state_reg == S_DONE) ? 1'b1 :
                           (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            unused_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            unused_reg   <= unused_next;
            if (state_reg != S_DONE || out_free)
            begin
                m_tvalid_reg <= m_tvalid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            func_reg <= func_t'(s_tuser);
            sym_reg  <= s_tdata[7:0];
            w_reg    <= s_tdata[39:8];
        end
        if (state_reg == S_MARK_A)
        begin
            a_idx_reg <= scan_res.idx;
            wa_reg    <= scan_res.entry.weight;
        end
        if (state_reg == S_MARK_B)
        begin
            b_idx_reg <= scan_res.idx;
            // saturate the parent weight on carry out
            sum_reg   <= sum_wide[WEIGHT_W] ? {WEIGHT_W{1'b1}} : sum_wide[WEIGHT_W-1:0];
        end
        // load the output register; counts are already final here
        if (state_reg == S_DONE && out_free)
        begin
            out_res_reg  <= res_reg;
            out_room_reg <= (fill_reg < CNT_W'(TABLE_SLOTS));
            out_root_reg <= (unused_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_root_reg, out_room_reg,
                       out_res_reg.right_child, out_res_reg.left_child,
                       out_res_reg.node_weight, out_res_reg.slot};
    assign m_tuser  = out_res_reg.status;

endmodule

// ===== sim/huffman_tree_merge_table_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for huffman_tree_merge_table: directed and random item
// streams, checked against a node-table predictor. Depends on htm_pkg and the RTL.
module huffman_tree_merge_table_test;

    import htm_pkg::*;

    // Func code 3 is left out of func_t; the block must ignore it.
    localparam logic [1:0] FN_UNUSED = 2'd3;

    // One result item as unpacked from m_tdata and m_tuser.
    typedef struct packed {
        logic [IDX_W-1:0]    slot;
        logic [WEIGHT_W-1:0] node_weight;
        logic [IDX_W-1:0]    left_child;
        logic [IDX_W-1:0]    right_child;
        status_t             status;
        logic                has_room;
        logic                root_ready;
    } tree_result_t;

    // Mirrors the node table (weights and used marks are all that reach the outputs)
    // and holds the results owed by the block, oldest first.
    class merge_table_tracker;
        logic [WEIGHT_W-1:0] freq [TABLE_SLOTS];
        bit                  taken [TABLE_SLOTS];
        int                  fill;
        int                  live;
        tree_result_t        due_results [$];
        int                  errors;
        int                  checked;
        int                  merges;
        int                  saturated;
        int                  no_room;
        int                  few_nodes;

        // Take the unused node of least weight, lowest slot on a tie.
        function int take_lightest();
            int best;
            best = -1;
            for (int i = 0; i < fill; i++)
                if (!taken[i] && (best < 0 || freq[i] < freq[best]))
                    best = i;
            taken[best] = 1'b1;
            return best;
        endfunction

        function void note_item(logic [1:0] fn, logic [WEIGHT_W-1:0] w);
            tree_result_t r;
            int           a;
            int           b;
            logic [WEIGHT_W:0] sum;
            r = '0;
            case (fn)
                FN_CLEAR:
                begin
                    fill = 0;
                    live = 0;
                end
                FN_LOAD:
                begin
                    if (fill >= TABLE_SLOTS)
                    begin
                        r.status = STS_NO_ROOM;
                        no_room++;
                    end
                    else
                    begin
                        r.slot = fill[IDX_W-1:0];
                        r.node_weight = w;
                        freq[fill] = w;
                        taken[fill] = 1'b0;
                        fill++;
                        live++;
                    end
                end
                FN_MERGE:
                begin
                    if (live < 2)
                    begin
                        r.status = STS_FEW_NODES;
                        few_nodes++;
                    end
                    else if (fill >= TABLE_SLOTS)
                    begin
                        r.status = STS_NO_ROOM;
                        no_room++;
                    end
                    else
                    begin
                        a = take_lightest();
                        b = take_lightest();
                        sum = freq[a] + freq[b];
                        r.slot = fill[IDX_W-1:0];
                        r.node_weight = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
                        r.left_child = a[IDX_W-1:0];
                        r.right_child = b[IDX_W-1:0];
                        if (sum[WEIGHT_W])
                            saturated++;
                        freq[fill] = r.node_weight;
                        taken[fill] = 1'b0;
                        fill++;
                        live--;
                        merges++;
                    end
                end
                default: ;
            endcase
            r.has_room = (fill < TABLE_SLOTS);
            r.root_ready = (live == 1);
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: %s expected 0x%0h, got 0x%0h",
                             checked, name, want, got);
            end
        endfunction

        function void check_result(logic [63:0] d, logic [1:0] u);
            tree_result_t want;
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item: tdata 0x%0h, tuser %0d", d, u);
                return;
            end
            want = due_results.pop_front();
            compare_field("slot", 32'(want.slot), 32'(d[8:0]));
            compare_field("node_weight", want.node_weight, d[40:9]);
            compare_field("left_child", 32'(want.left_child), 32'(d[49:41]));
            compare_field("right_child", 32'(want.right_child), 32'(d[58:50]));
            compare_field("status", 32'(want.status), 32'(u));
            compare_field("has_room", 32'(want.has_room), 32'(d[59]));
            compare_field("root_ready", 32'(want.root_ready), 32'(d[60]));
            checked++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // symbol[7:0], weight[39:8]
    logic [1:0]  s_tuser = '0;     // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // slot, node_weight, left_child, right_child,
                                   // has_room, root_ready
    logic [1:0]  m_tuser;          // status[1:0]

    merge_table_tracker tracker;
    int items_sent = 0;
    int results_seen = 0;
    int hold_left = 0;
    int send_idle_pct = 11;
    int recv_idle_pct = 77;

    huffman_tree_merge_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receive side: check every accepted result, then pick the next ready level.
    // Twice in the run, hold ready low for a long stretch so the block backs up
    // into its input while the sender keeps offering items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                tracker.check_result(m_tdata, m_tuser);
                results_seen++;
                if (results_seen == 30 || results_seen == 400)
                    hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Often small weights so ties are common, plus full-range, the extremes and near-overflow.
    function automatic logic [31:0] pick_weight();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'hFFFF_FFFF - $urandom_range(255);
            3, 4, 5: return $urandom_range(15);
            default: return $urandom();
        endcase
    endfunction

    // Offer one item, hold it until accepted, then note it in the tracker.
    // Idle windows shift by item count: sender-light, receiver-light, then none.
    task automatic send_item(logic [1:0] fn, logic [7:0] sym, logic [31:0] w);
        if (items_sent < 200)
        begin
            send_idle_pct = 11;
            recv_idle_pct = 77;
        end
        else if (items_sent < 400)
        begin
            send_idle_pct = 77;
            recv_idle_pct = 11;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w, sym};
        s_tuser  <= fn;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_item(fn, w);
        items_sent++;
    endtask

    // Clear, then load leaves and merge them down to one root in random order,
    // with some ignored codes, stray merges and extra leaves mixed in.
    task automatic grow_tree(int leaves);
        int to_load;
        to_load = leaves;
        send_item(FN_CLEAR, 8'($urandom), $urandom);
        while (to_load > 0 || tracker.live > 1)
        begin
            if ($urandom_range(99) < 6)
            begin
                case ($urandom_range(2))
                    0:       send_item(FN_UNUSED, 8'($urandom), $urandom);
                    1:       send_item(FN_MERGE, 8'($urandom), $urandom);
                    default: send_item(FN_LOAD, 8'($urandom), pick_weight());
                endcase
            end
            else if (to_load > 0 && (tracker.live < 2 || $urandom_range(1)))
            begin
                send_item(FN_LOAD, 8'($urandom), pick_weight());
                to_load--;
            end
            else
                send_item(FN_MERGE, 8'($urandom), $urandom);
        end
        if ($urandom_range(1))
            send_item(FN_MERGE, 8'($urandom), $urandom);
    endtask

    // Fill every slot with half-plus-one leaves and merges, leaving two unused
    // nodes, so both a load and a merge then hit the full table.
    task automatic fill_table();
        int to_load;
        to_load = TABLE_SLOTS / 2 + 1;
        send_item(FN_CLEAR, 8'($urandom), $urandom);
        while (tracker.fill < TABLE_SLOTS)
        begin
            if (to_load > 0 && (tracker.live < 2 || $urandom_range(1)))
            begin
                send_item(FN_LOAD, 8'($urandom), pick_weight());
                to_load--;
            end
            else
                send_item(FN_MERGE, 8'($urandom), $urandom);
        end
        send_item(FN_LOAD, 8'($urandom), $urandom);
        send_item(FN_MERGE, 8'($urandom), $urandom);
        send_item(FN_UNUSED, 8'($urandom), $urandom);
        send_item(FN_CLEAR, 8'($urandom), $urandom);
        send_item(FN_LOAD, 8'($urandom), pick_weight());
        send_item(FN_MERGE, 8'($urandom), $urandom);
    endtask

    initial
    begin
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table merge, extreme weights and symbols, ties on the
        // lowest slot, saturating sums, ignored code 3, and clear.
        send_item(FN_MERGE, 8'h00, 32'h0000_0000);
        send_item(FN_LOAD, 8'h00, 32'h0000_0000);
        send_item(FN_MERGE, 8'hFF, 32'hFFFF_FFFF);
        send_item(FN_LOAD, 8'hFF, 32'hFFFF_FFFF);
        send_item(FN_LOAD, 8'hA5, 32'hFFFF_FFFF);
        send_item(FN_LOAD, 8'h5A, 32'h0000_0000);
        send_item(FN_MERGE, 8'h00, 32'h0000_0000);
        send_item(FN_MERGE, 8'h00, 32'h0000_0000);
        send_item(FN_MERGE, 8'h00, 32'h0000_0000);
        send_item(FN_MERGE, 8'h00, 32'h0000_0000);
        send_item(FN_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        send_item(FN_CLEAR, 8'hFF, 32'hFFFF_FFFF);
        send_item(FN_UNUSED, 8'h00, 32'h0000_0000);
        send_item(FN_LOAD, 8'h01, 32'h8000_0000);
        send_item(FN_LOAD, 8'h80, 32'h8000_0000);
        send_item(FN_LOAD, 8'h7F, 32'h7FFF_FFFF);
        send_item(FN_LOAD, 8'h55, 32'h0000_0001);
        send_item(FN_MERGE, 8'h00, 32'h0000_0000);
        send_item(FN_MERGE, 8'h00, 32'h0000_0000);
        send_item(FN_MERGE, 8'h00, 32'h0000_0000);
        send_item(FN_CLEAR, 8'h00, 32'h0000_0000);

        // Random: many small trees first, then one run up to a full table.
        while (items_sent < 60)
            grow_tree($urandom_range(1, 12));
        fill_table();

        @(posedge clk);
        s_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d items and checked %0d results: %0d merges (%0d saturated),",
                 items_sent, tracker.checked, tracker.merges, tracker.saturated);
        $display("%0d full-table and %0d too-few-node errors, table filled to the last slot.",
                 tracker.no_room, tracker.few_nodes);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #50_000_000;
        $display("timeout with %0d results still owed", tracker.due_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/htm_pkg.sv
rtl/htm_ram.sv
rtl/htm_min_scan.sv
rtl/huffman_tree_merge_table.sv
sim/huffman_tree_merge_table_test.sv
